// ===== rtl/weighted_dominant_color_class_top_assert.svh =====
// Assertion macros for the weighted dominant color class block.
// Used by the port checker; depends on nothing else.
`ifndef WEIGHTED_DOMINANT_COLOR_CLASS_TOP_ASSERT_SVH
`define WEIGHTED_DOMINANT_COLOR_CLASS_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WDCC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wdcc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define WDCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wdcc assertion failed");

`endif

// ===== rtl/wdcc_pkg.sv =====
// Shared constants, command codes and control/status structs of the
// weighted dominant color class block. Depends on nothing.
package wdcc_pkg;

  localparam int NUM_CLASSES_DEF  = 512;
  localparam int CHANNEL_BITS_DEF = 8;
  localparam int WEIGHT_BITS_DEF  = 32;

  localparam int CHAN_W      = 16;
  localparam int ADDR_W      = 24;
  localparam int CLASS_W     = 9;
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 16;

  // Field offsets inside in_tdata.
  localparam int ADDR_LSB  = 0;
  localparam int CLASS_LSB = 24;
  localparam int RED_LSB   = 33;
  localparam int GREEN_LSB = 49;
  localparam int BLUE_LSB  = 65;
  localparam int ALPHA_LSB = 81;

  // Command codes carried in in_tuser.
  localparam logic CMD_TABLE_WRITE = 1'b0;
  localparam logic CMD_PIXEL       = 1'b1;

  typedef struct packed {
    logic tbl_write;    // write class table entry from input
    logic tbl_read;     // look up class of the input pixel
    logic pix_capture;  // latch pixel weight and last flag
    logic wt_read;      // read the total of the looked-up class
    logic wt_update;    // write back saturated total, update best
    logic wt_clear;     // zero one total at the clear counter
    logic clr_start;    // restart the clear counter
    logic out_load;     // load result register and reset best
  } wdcc_cmd_t;

  typedef struct packed {
    logic in_range;     // looked-up class is below NUM_CLASSES
    logic last;         // current pixel closes the region
    logic clr_done;     // clear counter is at the last class
  } wdcc_stat_t;

endpackage

// ===== rtl/wdcc_ram.sv =====
// Generic single-port RAM with registered read data.
// Depends on nothing.
module wdcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/wdcc_ctrl.sv =====
// Sequencer of the weighted dominant color class block.
// Depends on wdcc_pkg for command codes and the control/status structs.
module wdcc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic               in_tuser,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  wdcc_pkg::wdcc_stat_t stat,
  output wdcc_pkg::wdcc_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TLOOK,
    ST_WREAD,
    ST_FLUSH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.wt_clear = 1'b1;
        if (stat.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_tuser == wdcc_pkg::CMD_PIXEL) begin
            cmd.tbl_read    = 1'b1;
            cmd.pix_capture = 1'b1;
            state_nxt       = ST_TLOOK;
          end else begin
            cmd.tbl_write = 1'b1;
          end
        end
      end
      ST_TLOOK: begin
        if (stat.in_range) begin
          cmd.wt_read = 1'b1;
          state_nxt   = ST_WREAD;
        end else begin
          state_nxt = stat.last ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_WREAD: begin
        cmd.wt_update = 1'b1;
        state_nxt     = stat.last ? ST_FLUSH : ST_IDLE;
      end
      ST_FLUSH: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          cmd.clr_start = 1'b1;
          state_nxt     = ST_CLEAR;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
    out_valid_nxt = cmd.out_load || (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/wdcc_datapath.sv =====
// Datapath: class table, per-class weight totals, running best and result register.
// Depends on wdcc_pkg and wdcc_ram.
module wdcc_datapath #(
  parameter int NUM_CLASSES  = wdcc_pkg::NUM_CLASSES_DEF,
  parameter int CHANNEL_BITS = wdcc_pkg::CHANNEL_BITS_DEF,
  parameter int WEIGHT_BITS  = wdcc_pkg::WEIGHT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [wdcc_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                in_tlast,
  input  wdcc_pkg::wdcc_cmd_t                 cmd,
  output wdcc_pkg::wdcc_stat_t                stat,
  output logic [wdcc_pkg::CLASS_W-1:0]        dominant_class
);

  localparam int TBL_AW = 3 * CHANNEL_BITS;
  localparam int CLS_AW = $clog2(NUM_CLASSES);
  localparam int CW     = wdcc_pkg::CLASS_W;
  localparam int HW     = wdcc_pkg::CHAN_W;

  logic [TBL_AW-1:0]      tbl_addr, pix_addr;
  logic [CW-1:0]          tbl_wdata, tbl_rdata;
  logic [HW-1:0]          red, green, blue, alpha, weight_in;
  logic [CLS_AW-1:0]      wt_addr, clr_cnt_r;
  logic [WEIGHT_BITS-1:0] wt_wdata, wt_rdata, total, weight_r, best_w_r;
  logic [WEIGHT_BITS:0]   sum;
  logic [CW-1:0]          cls_r, best_cls_r, dom_r;
  logic                   last_r, any_seen_r, take_best;

  assign red   = in_tdata[wdcc_pkg::RED_LSB   +: HW];
  assign green = in_tdata[wdcc_pkg::GREEN_LSB +: HW];
  assign blue  = in_tdata[wdcc_pkg::BLUE_LSB  +: HW];
  assign alpha = in_tdata[wdcc_pkg::ALPHA_LSB +: HW];

  // The pixel weight 65535 - alpha is the bitwise complement of the 16-bit alpha.
  assign weight_in = ~alpha;

  // Table index is the top channel bits of red, green and blue.
  assign pix_addr  = {red[HW-1 -: CHANNEL_BITS], green[HW-1 -: CHANNEL_BITS],
                      blue[HW-1 -: CHANNEL_BITS]};
  assign tbl_addr  = cmd.tbl_write ? in_tdata[wdcc_pkg::ADDR_LSB +: TBL_AW] : pix_addr;
  assign tbl_wdata = in_tdata[wdcc_pkg::CLASS_LSB +: CW];

  wdcc_ram #(.WIDTH(CW), .DEPTH(2 ** TBL_AW)) u_tbl_ram (
    .clk   (clk),
    .en    (cmd.tbl_write || cmd.tbl_read),
    .we    (cmd.tbl_write),
    .addr  (tbl_addr),
    .wdata (tbl_wdata),
    .rdata (tbl_rdata)
  );

  always_comb begin
    priority if (cmd.wt_clear) wt_addr = clr_cnt_r;
    else if (cmd.wt_read)      wt_addr = CLS_AW'(tbl_rdata);
    else                       wt_addr = CLS_AW'(cls_r);
  end

  // Saturating accumulate of the pixel weight.
  assign sum      = {1'b0, wt_rdata} + {1'b0, weight_r};
  assign total    = sum[WEIGHT_BITS] ? '1 : sum[WEIGHT_BITS-1:0];
  assign wt_wdata = cmd.wt_clear ? '0 : total;

  wdcc_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(NUM_CLASSES)) u_wt_ram (
    .clk   (clk),
    .en    (cmd.wt_read || cmd.wt_update || cmd.wt_clear),
    .we    (cmd.wt_update || cmd.wt_clear),
    .addr  (wt_addr),
    .wdata (wt_wdata),
    .rdata (wt_rdata)
  );

  assign take_best = !any_seen_r || (total > best_w_r) ||
                     ((total == best_w_r) && (cls_r < best_cls_r));

  always_ff @(posedge clk) begin
    if (cmd.pix_capture) begin
      weight_r <= WEIGHT_BITS'(weight_in);
      last_r   <= in_tlast;
    end
    if (cmd.wt_read) cls_r <= tbl_rdata;
    if (cmd.out_load) dom_r <= any_seen_r ? best_cls_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      any_seen_r <= 1'b0;
      best_cls_r <= '0;
      best_w_r   <= '0;
    end else begin
      if (cmd.clr_start) begin
        clr_cnt_r <= '0;
      end else if (cmd.wt_clear) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cmd.out_load) begin
        any_seen_r <= 1'b0;
        best_cls_r <= '0;
        best_w_r   <= '0;
      end else if (cmd.wt_update) begin
        any_seen_r <= 1'b1;
        if (take_best) begin
          best_cls_r <= cls_r;
          best_w_r   <= total;
        end
      end
    end
  end

  assign stat.in_range   = (32'(tbl_rdata) < NUM_CLASSES);
  assign stat.last       = last_r;
  assign stat.clr_done   = (clr_cnt_r == CLS_AW'(NUM_CLASSES - 1));
  assign dominant_class  = dom_r;

endmodule

// ===== rtl/weighted_dominant_color_class_top.sv =====
// Top level of the weighted dominant color class block.
// Depends on wdcc_pkg, wdcc_ctrl, wdcc_datapath and wdcc_ram.
//
// Usage. The input stream carries two kinds of transfer, told apart by in_tuser.
// A table write (in_tuser = 0) stores class_value at table_address in the class
// table, and the input stays open. A pixel (in_tuser = 1) looks up its class
// from the top CHANNEL_BITS bits of red, green and blue and, if that class is
// below NUM_CLASSES, adds 65535 minus alpha to its saturating total. A pixel
// steps through table read, total read and total write-back, the last two only
// for a class in range; the two dependent RAM reads force these separate steps.
// in_tlast marks the last pixel of a region. After it the block loads the result
// register once the output is free, then zeroes the totals RAM, one entry per
// cycle, with in_tready low. The result (the class with the greatest total,
// lowest id on ties, 0 for an empty region) thus appears on the output when it
// is loaded. After reset the same clearing pass runs before the first
// input transfer is taken. The class table is not cleared and must be written
// before pixels use it. If the receiver stalls, the result is held in the output
// register while new items keep being taken; only a further last pixel waits
// until the pending result has been transferred.
module weighted_dominant_color_class_top #(
  parameter int NUM_CLASSES  = wdcc_pkg::NUM_CLASSES_DEF,
  parameter int CHANNEL_BITS = wdcc_pkg::CHANNEL_BITS_DEF,
  parameter int WEIGHT_BITS  = wdcc_pkg::WEIGHT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // in_tdata from bit 0 up: table_address[23:0], class_value[32:24], red[48:33],
  // green[64:49], blue[80:65], alpha[96:81], zero fill [103:97].
  input  logic [wdcc_pkg::IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: command (0 = table write, 1 = pixel).
  input  logic                             in_tuser,
  // in_tlast: last_pixel.
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_tdata from bit 0 up: dominant_class[8:0], zero fill [15:9].
  output logic [wdcc_pkg::OUT_TDATA_W-1:0] out_tdata
);

  wdcc_pkg::wdcc_cmd_t  cmd;
  wdcc_pkg::wdcc_stat_t stat;
  logic [wdcc_pkg::CLASS_W-1:0] dominant_class;

  // The sequencer owns both handshakes; the datapath only sees commands.
  wdcc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  wdcc_datapath #(
    .NUM_CLASSES  (NUM_CLASSES),
    .CHANNEL_BITS (CHANNEL_BITS),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .cmd            (cmd),
    .stat           (stat),
    .dominant_class (dominant_class)
  );

  // The result field sits in the low bits; the rest of the byte-padded bus is zero.
  assign out_tdata = {{(wdcc_pkg::OUT_TDATA_W - wdcc_pkg::CLASS_W){1'b0}}, dominant_class};

endmodule

// ===== rtl/wdcc_checker.sv =====
// Port-level checker for the weighted dominant color class block, with its bind.
// Depends on wdcc_pkg and the assertion macro header.
`include "weighted_dominant_color_class_top_assert.svh"

module wdcc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [wdcc_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // A stalled result stays offered and unchanged.
  `WDCC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `WDCC_ASSERT_NEXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata))

  // A table write finishes in its own cycle, so the input stays open.
  `WDCC_ASSERT_NEXT(a_tbl_write_open, clk, rst_n,
    in_tvalid && in_tready && (in_tuser == wdcc_pkg::CMD_TABLE_WRITE), in_tready)

  // A pixel occupies the lookup pipeline, so the input closes the next cycle.
  `WDCC_ASSERT_NEXT(a_pixel_busy, clk, rst_n,
    in_tvalid && in_tready && (in_tuser == wdcc_pkg::CMD_PIXEL), !in_tready)

endmodule

bind weighted_dominant_color_class_top wdcc_checker u_wdcc_checker (.*);

// ===== verif/weighted_dominant_color_class_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for weighted_dominant_color_class_top: a clocked driver and monitor
// around the block, with a transaction-level predictor of the dominant class of each pixel region.
// Depends on wdcc_pkg and the block's RTL only.
module weighted_dominant_color_class_top_test;

  localparam int NC = wdcc_pkg::NUM_CLASSES_DEF;
  localparam int CB = wdcc_pkg::CHANNEL_BITS_DEF;
  localparam int WB = wdcc_pkg::WEIGHT_BITS_DEF;
  localparam logic [WB-1:0] TOTAL_MAX = '1;

  localparam int ADDR_W      = wdcc_pkg::ADDR_W;
  localparam int CLASS_W     = wdcc_pkg::CLASS_W;
  localparam int CHAN_W      = wdcc_pkg::CHAN_W;
  localparam int FILL_W      = 3 * CHAN_W;
  localparam int IN_TDATA_W  = wdcc_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = wdcc_pkg::OUT_TDATA_W;
  localparam int ADDR_LSB    = wdcc_pkg::ADDR_LSB;
  localparam int CLASS_LSB   = wdcc_pkg::CLASS_LSB;
  localparam int RED_LSB     = wdcc_pkg::RED_LSB;
  localparam int GREEN_LSB   = wdcc_pkg::GREEN_LSB;
  localparam int BLUE_LSB    = wdcc_pkg::BLUE_LSB;
  localparam int ALPHA_LSB   = wdcc_pkg::ALPHA_LSB;

  // The longest correct stretch without any transfer is the clearing pass, plus the long
  // receiver hold-off, plus a short stall. The limit is several times that.
  localparam int STALL_LIMIT = 5000;
  localparam int PRESSURE_HOLD = 400;
  // After the last result the block still runs its clearing pass over the totals.
  localparam int DRAIN_CYCLES = NC + 64;
  // Below this many pending items neither side idles any more.
  localparam int TAIL_ITEMS = 200;
  // Opaque pixels piled onto one class in the heavy region.
  localparam int HEAVY_PIXELS = 20;
  localparam int RANDOM_ITEMS = 1160;

  // One input item as the generator sees it, before packing onto the bus.
  typedef struct packed {
    logic                cmd;
    logic [ADDR_W-1:0]   addr;
    logic [CLASS_W-1:0]  cls;
    logic [CHAN_W-1:0]   red;
    logic [CHAN_W-1:0]   green;
    logic [CHAN_W-1:0]   blue;
    logic [CHAN_W-1:0]   alpha;
    logic                last;
  } xfer_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   in_tlast   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  weighted_dominant_color_class_top #(
    .NUM_CLASSES  (NC),
    .CHANNEL_BITS (CB),
    .WEIGHT_BITS  (WB)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Items waiting to be driven, and every table address written so far by the generator.
  // Pixels only ever look up addresses from that list, so no unwritten entry is read.
  xfer_t             pending [$];
  logic [ADDR_W-1:0] known_addrs [$];

  // Predictor state: its own copy of the class table and the per-region totals.
  logic [CLASS_W-1:0] palette [bit [ADDR_W-1:0]];
  logic [WB-1:0]      class_total [NC] = '{default: '0};
  logic [CLASS_W-1:0] best_class = '0;
  logic [WB-1:0]      best_total = '0;
  logic               any_hit    = 1'b0;
  // Dominant classes that the block still owes, oldest first.
  logic [CLASS_W-1:0] dominant_q [$];

  int   n_errors      = 0;
  int   n_taken       = 0;
  logic in_taken      = 1'b0;
  int   send_gap      = 0;
  int   send_calm     = 0;
  int   recv_gap      = 0;
  int   recv_calm     = 0;
  int   hold_left     = 0;
  logic pressure_done = 1'b0;
  int   pressure_at   = 32'h7fff_ffff;
  int   quiet_cycles  = 0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    n_errors++;
  endtask

  function automatic void clear_region();
    foreach (class_total[i]) class_total[i] = '0;
    best_class = '0;
    best_total = '0;
    any_hit    = 1'b0;
  endfunction

  // Applies one accepted input transfer to the predictor. A table write only updates the
  // class table; a pixel adds its weight to its class, keeps the running best current, and
  // on the last pixel of a region queues the dominant class and starts a fresh region.
  function automatic void tally_transfer(input logic cmd, input logic [IN_TDATA_W-1:0] d,
                                         input logic last);
    logic [ADDR_W-1:0]  idx;
    logic [CLASS_W-1:0] cls;
    logic [CHAN_W-1:0]  weight;
    logic [WB:0]        sum;
    logic [WB-1:0]      total;
    if (cmd == wdcc_pkg::CMD_TABLE_WRITE) begin
      palette[d[ADDR_LSB +: ADDR_W]] = d[CLASS_LSB +: CLASS_W];
      return;
    end
    // Only the top CB bits of each channel form the table index.
    idx = (ADDR_W'(d[RED_LSB +: CHAN_W] >> (CHAN_W - CB)) << (2 * CB))
        | (ADDR_W'(d[GREEN_LSB +: CHAN_W] >> (CHAN_W - CB)) << CB)
        |  ADDR_W'(d[BLUE_LSB +: CHAN_W] >> (CHAN_W - CB));
    cls = palette.exists(idx) ? palette[idx] : '0;
    weight = 16'hFFFF - d[ALPHA_LSB +: CHAN_W];
    if (cls < NC) begin
      // Totals saturate instead of wrapping.
      sum = class_total[cls] + weight;
      total = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[WB-1:0];
      class_total[cls] = total;
      // A class seen with zero weight still beats an empty region.
      if (!any_hit || total > best_total || (total == best_total && cls < best_class)) begin
        best_class = cls;
        best_total = total;
      end
      any_hit = 1'b1;
    end
    if (last) begin
      dominant_q.push_back(any_hit ? best_class : '0);
      clear_region();
    end
  endfunction

  // Places a CB-bit table coordinate in the top of a channel and random noise below it.
  function automatic logic [CHAN_W-1:0] chan_of(input logic [CB-1:0] top,
                                                input logic [CHAN_W-1:0] fill);
    logic [CHAN_W-1:0] low_mask;
    low_mask = (CHAN_W'(1) << (CHAN_W - CB)) - 1'b1;
    return (CHAN_W'(top) << (CHAN_W - CB)) | (fill & low_mask);
  endfunction

  // Queues a table write. The pixel fields and tlast are noise that the block must ignore.
  task automatic load_entry(input logic [ADDR_W-1:0] addr, input logic [CLASS_W-1:0] cls,
                            input logic last);
    xfer_t x;
    x.cmd   = wdcc_pkg::CMD_TABLE_WRITE;
    x.addr  = addr;
    x.cls   = cls;
    x.red   = CHAN_W'($urandom);
    x.green = CHAN_W'($urandom);
    x.blue  = CHAN_W'($urandom);
    x.alpha = CHAN_W'($urandom);
    x.last  = last;
    pending.push_back(x);
    known_addrs.push_back(addr);
  endtask

  // Queues a pixel whose channels index table entry idx; fill sets the unused channel bits.
  task automatic send_pixel(input logic [ADDR_W-1:0] idx, input logic [FILL_W-1:0] fill,
                            input logic [CHAN_W-1:0] alpha, input logic last);
    xfer_t x;
    x.cmd   = wdcc_pkg::CMD_PIXEL;
    x.addr  = ADDR_W'($urandom);
    x.cls   = CLASS_W'($urandom);
    x.red   = chan_of(idx[2*CB +: CB], fill[2*CHAN_W +: CHAN_W]);
    x.green = chan_of(idx[CB +: CB], fill[CHAN_W +: CHAN_W]);
    x.blue  = chan_of(idx[0 +: CB], fill[0 +: CHAN_W]);
    x.alpha = alpha;
    x.last  = last;
    pending.push_back(x);
  endtask

  // Mostly a handful of low classes, so that regions collide and ties happen.
  function automatic logic [CLASS_W-1:0] pick_class();
    case ($urandom_range(0, 4))
      0:       return CLASS_W'($urandom_range(0, NC - 1));
      1:       return CLASS_W'(NC - 1);
      default: return CLASS_W'($urandom_range(0, 7));
    endcase
  endfunction

  // Weights at both ends and in the middle appear often; the rest are arbitrary.
  function automatic logic [CHAN_W-1:0] pick_alpha();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return 16'h8000;
      default: return CHAN_W'($urandom);
    endcase
  endfunction

  // Input monitor and result checker. Everything is sampled at the rising edge, after the
  // driver and the receiver have changed their signals at the falling edge.
  always @(posedge clk) begin : sample
    logic [CLASS_W-1:0] want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        tally_transfer(in_tuser, in_tdata, in_tlast);
        n_taken <= n_taken + 1;
      end
      if (out_tvalid && out_tready) begin
        if (dominant_q.size() == 0) begin
          report_mismatch($sformatf("result class %0d with no region pending",
                                    out_tdata[CLASS_W-1:0]));
        end else begin
          want = dominant_q.pop_front();
          if (out_tdata[CLASS_W-1:0] !== want)
            report_mismatch($sformatf("dominant_class %0d, expected %0d",
                                      out_tdata[CLASS_W-1:0], want));
        end
      end
    end
  end

  // Sender. A new item goes out only when the bus is empty or its last transfer completed;
  // an offered item is held until it is taken. Idle bursts come at random, except during
  // calm stretches and at the tail of the run.
  always @(negedge clk) begin : drive
    xfer_t x;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (send_gap > 0) begin
        send_gap  <= send_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (send_calm == 0 && pending.size() > TAIL_ITEMS
                   && $urandom_range(0, 9) == 0) begin
        send_gap  <= $urandom_range(0, 6);
        in_tvalid <= 1'b0;
      end else begin
        x = pending.pop_front();
        in_tdata  <= IN_TDATA_W'({x.alpha, x.blue, x.green, x.red, x.cls, x.addr});
        in_tuser  <= x.cmd;
        in_tlast  <= x.last;
        in_tvalid <= 1'b1;
      end
    end
    if (send_calm > 0)
      send_calm <= send_calm - 1;
    else if ($urandom_range(0, 199) == 0)
      send_calm <= $urandom_range(50, 300);
  end

  // Receiver. Besides short random stalls it holds off once for a long stretch while the
  // sender keeps offering; the block then has to park its result and, at the next last
  // pixel, stall its input until the parked result has gone.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (!pressure_done && n_taken >= pressure_at) begin
      pressure_done <= 1'b1;
      hold_left     <= PRESSURE_HOLD - 1;
      out_tready    <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap   <= recv_gap - 1;
      out_tready <= 1'b0;
    end else if (recv_calm == 0 && pending.size() > TAIL_ITEMS
                 && $urandom_range(0, 7) == 0) begin
      recv_gap   <= $urandom_range(0, 6);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
    if (recv_calm > 0)
      recv_calm <= recv_calm - 1;
    else if ($urandom_range(0, 199) == 0)
      recv_calm <= $urandom_range(50, 300);
  end

  // Watchdog: ends the run when no transfer happens on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("weighted_dominant_color_class_top_test: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus is built up front, then reset is released and the run drains to its end.
  initial begin : stimulus
    int                random_base;
    int                region_len;
    logic [ADDR_W-1:0] a;

    // Directed part. Table writes cover both address extremes and both class extremes;
    // the one with tlast set checks that a write never closes a region.
    load_entry(24'h000000, 9'd0, 1'b0);
    load_entry(24'hFFFFFF, CLASS_W'(NC - 1), 1'b1);
    load_entry(24'h123456, 9'd7, 1'b0);
    load_entry(24'hABCDEF, 9'd3, 1'b0);
    load_entry(24'h00FF00, 9'd300, 1'b0);
    // A single fully transparent pixel: its class was seen with zero weight and still wins.
    send_pixel(24'hFFFFFF, '1, 16'hFFFF, 1'b1);
    // Equal totals: the higher class comes first, the lower class id must win the tie.
    send_pixel(24'h123456, FILL_W'({$urandom, $urandom}), 16'd100, 1'b0);
    send_pixel(24'hABCDEF, FILL_W'({$urandom, $urandom}), 16'd100, 1'b1);
    // Class 0 leads at first and is overtaken by one unit of weight.
    send_pixel(24'h000000, '0, 16'h0000, 1'b0);
    send_pixel(24'hFFFFFF, '1, 16'h0000, 1'b0);
    send_pixel(24'hFFFFFF, FILL_W'({$urandom, $urandom}), 16'hFFFE, 1'b1);
    // The totals of the previous region must be gone.
    send_pixel(24'h00FF00, FILL_W'({$urandom, $urandom}), 16'h8000, 1'b1);
    // Rewriting an entry redirects its pixels.
    load_entry(24'h123456, CLASS_W'(NC - 1), 1'b0);
    send_pixel(24'h123456, FILL_W'({$urandom, $urandom}), 16'h0000, 1'b1);
    send_pixel(24'h000000, '0, 16'hFFFF, 1'b1);

    // Heavy region: one class gathers many opaque pixels and must stay ahead of a lower
    // class that holds a single opaque pixel.
    load_entry(24'h5A5A5A, 9'd200, 1'b0);
    load_entry(24'h010203, 9'd100, 1'b1);
    repeat (HEAVY_PIXELS)
      send_pixel(24'h5A5A5A, FILL_W'({$urandom, $urandom}), 16'h0000, 1'b0);
    send_pixel(24'h010203, FILL_W'({$urandom, $urandom}), 16'h0000, 1'b0);
    send_pixel(24'h5A5A5A, FILL_W'({$urandom, $urandom}), 16'h0000, 1'b1);

    // Random part: regions of mostly short length over known entries, with table writes
    // in front of some regions and now and then a stray write in the middle of one.
    random_base = pending.size();
    pressure_at = random_base + 300;
    while (pending.size() - random_base < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 3) == 0)
            a = known_addrs[$urandom_range(0, known_addrs.size() - 1)];
          else
            a = ADDR_W'($urandom);
          load_entry(a, pick_class(), 1'($urandom_range(0, 1)));
        end
      end
      region_len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 12);
      for (int k = 1; k <= region_len; k++) begin
        if ($urandom_range(0, 9) == 0)
          load_entry(ADDR_W'($urandom), pick_class(), 1'($urandom_range(0, 1)));
        send_pixel(known_addrs[$urandom_range(0, known_addrs.size() - 1)],
                   FILL_W'({$urandom, $urandom}), pick_alpha(), k == region_len);
      end
    end

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Wait for the last item to be taken, for every owed result, and then for the clearing
    // pass, so that a stray extra result would still be caught.
    while (pending.size() != 0 || in_tvalid) @(posedge clk);
    while (dominant_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_errors == 0) begin
      $display("weighted_dominant_color_class_top_test: clean");
    end else begin
      $display("weighted_dominant_color_class_top_test: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/wdcc_pkg.sv
rtl/wdcc_ram.sv
rtl/wdcc_ctrl.sv
rtl/wdcc_datapath.sv
rtl/weighted_dominant_color_class_top.sv
rtl/wdcc_checker.sv
verif/weighted_dominant_color_class_top_test.sv
